>>> sv/mdpt_pkg.sv
// ----------------------------------------------------------------------------
// mdpt_pkg
// Shared types and constants for the minimum-distance point thinning unit.
// ----------------------------------------------------------------------------
package mdpt_pkg;

    localparam int FIELD_W        = 16;   // width of every coordinate field
    localparam int WINDOW_DEF     = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int GRP_SIZE       = 16;   // hit flags or-ed per group register

    typedef struct packed {
        logic [FIELD_W-1:0] x_coord;
        logic [FIELD_W-1:0] y_coord;
        logic               first_of_list;
    } t_pt_in;

    typedef struct packed {
        logic keep;
        logic order_error;
        logic window_overflow;
    } t_pt_out;

    // window control broadcast to every cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAP,
        S_SQR,
        S_CMP,
        S_GRP,
        S_END
    } t_state;

endpackage

>>> sv/min_distance_point_thinning_unit.sv
// ----------------------------------------------------------------------------
// min_distance_point_thinning_unit
// Greedy minimum-distance thinning of x-sorted points over a window of kept
// points held in a shifting row of cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | i_in_valid/o_in_stall | i_in_item  (t_pt_in)
//  out     | output    | o_out_valid/i_out_stall | o_out_item (t_pt_out)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (min_distance)
//
// a point passes through the request cycle, then gap, square and compare
// stages in every cell, a group or stage, and the keep decision and shift,
// after which the result sits in the output register.
// a new point is taken once the previous one has reached the output register;
// the result stays there while i_out_stall is high, and the unit waits at the
// decision step if the register is still occupied.
// reset is synchronous and clears the window valid bits at once.
module min_distance_point_thinning_unit
    import mdpt_pkg::*;
#(
    parameter int WINDOW     = WINDOW_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_pt_in             i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_pt_out            o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [FIELD_W-1:0] i_cfg_data
);

    localparam int CW   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int NGRP = (WINDOW + GRP_SIZE - 1) / GRP_SIZE;

    t_state r_state;
    t_state n_state;

    logic [CW-1:0]   r_dist;
    logic [2*CW-1:0] r_dist_sq;
    logic [CW-1:0]   r_px;
    logic [CW-1:0]   r_py;
    logic [CW-1:0]   r_prev_x;
    logic            r_oerr;
    logic [NGRP-1:0] r_grp;
    logic [NGRP-1:0] n_grp;
    t_pt_out         r_out;
    logic            r_out_valid;

    logic            w_accept;
    logic            w_done;
    logic            w_suppress;
    logic [CW-1:0]   w_in_x;
    t_cell_ctl       w_ctl;

    logic [CW-1:0]     w_kx    [WINDOW];
    logic [CW-1:0]     w_ky    [WINDOW];
    logic [WINDOW-1:0] w_kv;
    logic [WINDOW-1:0] w_xnear;
    logic [WINDOW-1:0] w_hit;

    assign w_in_x     = i_in_item.x_coord[CW-1:0];
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign w_suppress = |r_grp;

    always_comb begin
        n_state = r_state;
        w_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_GAP;
                end
            end
            S_GAP:  n_state = S_SQR;
            S_SQR:  n_state = S_CMP;
            S_CMP:  n_state = S_GRP;
            S_GRP:  n_state = S_END;
            S_END: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        w_ctl.clear = w_accept && i_in_item.first_of_list;
        w_ctl.shift = w_done && !w_suppress;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist      <= '0;
            r_prev_x    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_dist <= i_cfg_data[CW-1:0];
            end
            if (w_accept) begin
                r_prev_x <= w_in_x;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist_sq <= (2*CW)'(r_dist) * (2*CW)'(r_dist);
        r_grp     <= n_grp;
        if (w_accept) begin
            r_px   <= w_in_x;
            r_py   <= i_in_item.y_coord[CW-1:0];
            r_oerr <= !i_in_item.first_of_list && (w_in_x < r_prev_x);
        end
        if (w_done) begin
            r_out.keep            <= !w_suppress;
            r_out.order_error     <= r_oerr;
            r_out.window_overflow <= w_xnear[WINDOW-1];
        end
    end

    // first level of the hit reduction, one register per group of cells
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = 1'b0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                if (g * GRP_SIZE + k < WINDOW) begin
                    n_grp[g] = n_grp[g] | w_hit[g * GRP_SIZE + k];
                end
            end
        end
    end

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        logic [CW-1:0] w_sh_x;
        logic [CW-1:0] w_sh_y;
        logic          w_sh_v;

        if (i == 0) begin : g_head
            assign w_sh_x = r_px;
            assign w_sh_y = r_py;
            assign w_sh_v = 1'b1;
        end else begin : g_body
            assign w_sh_x = w_kx[i-1];
            assign w_sh_y = w_ky[i-1];
            assign w_sh_v = w_kv[i-1];
        end

        mdpt_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_px       (r_px),
            .i_py       (r_py),
            .i_dist     (r_dist),
            .i_dist_sq  (r_dist_sq),
            .i_sh_x     (w_sh_x),
            .i_sh_y     (w_sh_y),
            .i_sh_valid (w_sh_v),
            .o_kx       (w_kx[i]),
            .o_ky       (w_ky[i]),
            .o_kvalid   (w_kv[i]),
            .o_xnear    (w_xnear[i]),
            .o_hit      (w_hit[i])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> sv/mdpt_cell.sv
// ----------------------------------------------------------------------------
// mdpt_cell
// One slot of the kept-point window with its own distance test pipeline.
// ----------------------------------------------------------------------------
module mdpt_cell
    import mdpt_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_px,
    input  logic [CW-1:0] i_py,
    input  logic [CW-1:0] i_dist,
    input  logic [2*CW-1:0] i_dist_sq,
    input  logic [CW-1:0] i_sh_x,
    input  logic [CW-1:0] i_sh_y,
    input  logic          i_sh_valid,
    output logic [CW-1:0] o_kx,
    output logic [CW-1:0] o_ky,
    output logic          o_kvalid,
    output logic          o_xnear,
    output logic          o_hit
);

    localparam int W2 = 2 * CW;

    logic [CW-1:0] r_kx;
    logic [CW-1:0] r_ky;
    logic          r_kv;
    logic          n_kv;

    logic [CW-1:0] n_dx;
    logic [CW-1:0] n_dy;
    logic [CW-1:0] r_dx;
    logic [CW-1:0] r_dy;
    logic          r_xn;
    logic          r_near;
    logic [W2-1:0] r_dx2;
    logic [W2-1:0] r_dy2;
    logic          r_near2;
    logic          r_hit;
    logic [W2:0]   n_sum;

    always_comb begin
        n_kv = r_kv;
        if (i_ctl.clear) begin
            n_kv = 1'b0;
        end else if (i_ctl.shift) begin
            n_kv = i_sh_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kv <= 1'b0;
        end else begin
            r_kv <= n_kv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_kx <= i_sh_x;
            r_ky <= i_sh_y;
        end
    end

    assign n_dx  = (r_kx >= i_px) ? (r_kx - i_px) : (i_px - r_kx);
    assign n_dy  = (r_ky >= i_py) ? (r_ky - i_py) : (i_py - r_ky);
    assign n_sum = {1'b0, r_dx2} + {1'b0, r_dy2};

    // gap, square and compare stages run freely off the held point
    always_ff @(posedge i_clk) begin
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_xn    <= r_kv && (n_dx <= i_dist);
        r_near  <= r_kv && (n_dx <= i_dist) && (n_dy <= i_dist);
        r_dx2   <= W2'(r_dx) * W2'(r_dx);
        r_dy2   <= W2'(r_dy) * W2'(r_dy);
        r_near2 <= r_near;
        r_hit   <= r_near2 && (n_sum <= {1'b0, i_dist_sq});
    end

    assign o_kx     = r_kx;
    assign o_ky     = r_ky;
    assign o_kvalid = r_kv;
    assign o_xnear  = r_xn;
    assign o_hit    = r_hit;

endmodule

>>> sim/tb_min_distance_point_thinning_unit.sv
// ----------------------------------------------------------------------------
// tb_min_distance_point_thinning_unit
// Self-checking bench for the point thinning unit. A short table of points
// covers field extremes, out-of-order x, list restarts and a full window.
// Mostly x-sorted random lists with random content follow at several radius
// settings. Each result is compared with a table value or a behavioral
// predictor while both channels idle at random, save in the last two settings.
// ----------------------------------------------------------------------------
module tb_min_distance_point_thinning_unit
    import mdpt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN    = WINDOW_DEF;
    localparam int N_RAND = 100;     // points per radius setting

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic               first;
        logic [4:0]         reps;
        logic [FIELD_W-1:0] y_step;
        logic               typed;
        t_pt_out            want;
    } t_dir_row;

    // directed points, run at the reset radius of zero
    t_dir_row dir_rows [0:7] = '{
        '{16'h0000, 16'h0000, 1'b1, 5'd1,  16'h0000, 1'b1, 3'b100},
        '{16'h0000, 16'h0000, 1'b0, 5'd1,  16'h0000, 1'b1, 3'b000},
        '{16'h0010, 16'hFFFF, 1'b0, 5'd1,  16'h0000, 1'b1, 3'b100},
        '{16'h0008, 16'h0000, 1'b0, 5'd1,  16'h0000, 1'b1, 3'b110},
        '{16'h0000, 16'h0000, 1'b1, 5'd1,  16'h0000, 1'b1, 3'b100},
        '{16'hFFFF, 16'h0000, 1'b0, 5'd16, 16'h1000, 1'b0, 3'b000},
        '{16'hFFFF, 16'h0001, 1'b0, 5'd1,  16'h0000, 1'b0, 3'b000},
        '{16'hFFFF, 16'hF000, 1'b0, 5'd1,  16'h0000, 1'b0, 3'b000}
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               in_valid    = 1'b0;
    t_pt_in             in_item     = '0;
    logic               out_stall   = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic [FIELD_W-1:0] cfg_data    = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_pt_out            o_out_item;
    logic               o_cfg_ready;

    // predictor copy of the kept-point window
    logic [FIELD_W-1:0] win_x   [WIN];
    logic [FIELD_W-1:0] win_y   [WIN];
    logic               win_vld [WIN];
    logic [FIELD_W-1:0] last_x  = '0;
    logic [FIELD_W-1:0] radius  = '0;

    t_pt_out verdict_q [$];
    int      err_count = 0;
    int      send_idle = 0;
    int      recv_idle = 0;

    // random list generator state
    int          cur_x     = 0;
    int          list_left = 0;
    logic [15:0] y_base    = '0;

    min_distance_point_thinning_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint unsigned coord_gap(logic [FIELD_W-1:0] a,
                                                  logic [FIELD_W-1:0] b);
        return (a >= b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function automatic t_pt_out judge_point(t_pt_in p);
        t_pt_out          res;
        longint unsigned  dx;
        longint unsigned  dy;
        longint unsigned  d;
        logic             hit;
        res = '0;
        hit = 1'b0;
        d   = longint'(radius);
        if (p.first_of_list) begin
            for (int i = 0; i < WIN; i++) win_vld[i] = 1'b0;
        end else if (p.x_coord < last_x) begin
            res.order_error = 1'b1;
        end
        last_x = p.x_coord;
        for (int i = 0; i < WIN; i++) begin
            if (win_vld[i]) begin
                dx = coord_gap(win_x[i], p.x_coord);
                dy = coord_gap(win_y[i], p.y_coord);
                if (dx <= d && dy <= d && dy * dy <= d * d - dx * dx) hit = 1'b1;
            end
        end
        // oldest slot still reachable in x means older dropped points may matter
        if (win_vld[WIN-1] && coord_gap(win_x[WIN-1], p.x_coord) <= d)
            res.window_overflow = 1'b1;
        if (!hit) begin
            for (int i = WIN - 1; i > 0; i--) begin
                win_x[i]   = win_x[i-1];
                win_y[i]   = win_y[i-1];
                win_vld[i] = win_vld[i-1];
            end
            win_x[0]   = p.x_coord;
            win_y[0]   = p.y_coord;
            win_vld[0] = 1'b1;
        end
        res.keep = !hit;
        return res;
    endfunction

    task automatic send_point(input t_pt_in p, input logic typed, input t_pt_out want);
        t_pt_out calc;
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        calc = judge_point(p);
        verdict_q = {verdict_q, (typed ? want : calc)};
    endtask

    // drain all results, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [FIELD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        radius = value;
    endtask

    // mostly sorted lists clustered around the radius, some out-of-order noise
    task automatic next_point(output t_pt_in p);
        int step_max;
        int spread;
        step_max = int'(radius) / 4 + 1;
        spread   = (radius > 16383) ? 65535 : int'(radius) * 4 + 3;
        p = '0;
        if (list_left == 0) begin
            list_left       = $urandom_range(4, 70);
            cur_x           = $urandom_range(0, 65535);
            y_base          = 16'($urandom);
            p.first_of_list = 1'b1;
        end else begin
            list_left = list_left - 1;
            if ($urandom_range(0, 15) == 0) begin
                cur_x = $urandom_range(0, 65535);
            end else begin
                cur_x = cur_x + $urandom_range(0, step_max);
                if (cur_x > 65535) cur_x = 65535;
            end
        end
        p.x_coord = cur_x[15:0];
        if ($urandom_range(0, 15) == 0) p.y_coord = 16'($urandom);
        else p.y_coord = y_base + 16'($urandom_range(0, spread));
    endtask

    always @(posedge i_clk) begin : result_check
        t_pt_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected result %b", o_out_item);
                err_count++;
            end else begin
                want = verdict_q.pop_front();
                if (o_out_item.keep !== want.keep) begin
                    $error("keep: expected %0d, got %0d", want.keep, o_out_item.keep);
                    err_count++;
                end
                if (o_out_item.order_error !== want.order_error) begin
                    $error("order_error: expected %0d, got %0d",
                           want.order_error, o_out_item.order_error);
                    err_count++;
                end
                if (o_out_item.window_overflow !== want.window_overflow) begin
                    $error("window_overflow: expected %0d, got %0d",
                           want.window_overflow, o_out_item.window_overflow);
                    err_count++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    initial begin : stimulus
        logic [FIELD_W-1:0] radii [6];
        t_pt_in             pt;
        int                 k;
        radii = '{16'd24, 16'hFFFF, 16'd3, 16'd160, 16'd0, 16'd1};
        for (int i = 0; i < WIN; i++) begin
            win_x[i]   = '0;
            win_y[i]   = '0;
            win_vld[i] = 1'b0;
        end
        send_idle = 19;
        recv_idle = 87;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            pt               = '0;
            pt.x_coord       = dir_rows[r].x;
            pt.y_coord       = dir_rows[r].y;
            pt.first_of_list = dir_rows[r].first;
            for (k = 0; k < int'(dir_rows[r].reps); k++) begin
                send_point(pt, dir_rows[r].typed, dir_rows[r].want);
                pt.y_coord = pt.y_coord + dir_rows[r].y_step;
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_radius(radii[ph]);
            send_idle = (ph < 2) ? 19 : (ph < 4) ? 87 : 0;
            recv_idle = (ph < 2) ? 87 : (ph < 4) ? 19 : 0;
            list_left = 0;
            for (k = 0; k < N_RAND; k++) begin
                next_point(pt);
                send_point(pt, 1'b0, '0);
            end
        end

        wait_idle();
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
